// ===== hdl/tlpt_pkg.sv =====
package tlpt_pkg;

  localparam int NumSpaces = 4;
  localparam int NumCoarseTables = 512;
  localparam int SpaceBits = $clog2(NumSpaces);
  localparam int L1Depth = NumSpaces * 4096;
  localparam int L1AddrBits = $clog2(L1Depth);
  localparam int TableBits = $clog2(NumCoarseTables);
  localparam int L2AddrBits = TableBits + 8;
  localparam int TableCountBits = $clog2(NumCoarseTables + 1);

  typedef enum logic [1:0] {
    OP_MAP = 2'd0,
    OP_UNMAP = 2'd1,
    OP_SWAP = 2'd2,
    OP_SHARE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_BAD_VADDR = 3'd1,
    ST_BAD_PADDR = 3'd2,
    ST_BAD_PERM = 3'd3,
    ST_MAPPED = 3'd4,
    ST_NOT_MAPPED = 3'd5,
    ST_NO_TABLES = 3'd6
  } status_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [1:0] space;
    logic [31:0] vaddr;
    logic [31:0] paddr;
    logic [3:0] perm_code;
    logic [31:0] swap_id;
    logic [1:0] source_space;
    logic [31:0] source_vaddr;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [31:0] descriptor;
    logic table_allocated;
  } rsp_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_INIT,
    CMD_LOAD,
    CMD_RD_L1,
    CMD_RD_SRC_L1,
    CMD_EVAL,
    CMD_CLEAR,
    CMD_RD_L2,
    CMD_CHK_L2,
    CMD_CHK_SRC,
    CMD_OUT
  } cmd_t;

  typedef struct packed {
    logic init_last;
    logic ev_alloc;
    logic ev_l2;
    logic src_rd;
    logic clear_last;
  } stat_t;

  function automatic logic [4:0] perm_lookup(input logic [3:0] code);
    case (code)
      4'd0: perm_lookup = 5'h10;
      4'd1: perm_lookup = 5'h15;
      4'd2: perm_lookup = 5'h16;
      4'd3: perm_lookup = 5'h16;
      4'd4: perm_lookup = 5'h11;
      4'd6: perm_lookup = 5'h12;
      4'd8: perm_lookup = 5'h13;
      4'd12: perm_lookup = 5'h13;
      default: perm_lookup = 5'h00;
    endcase
  endfunction

endpackage

// ===== hdl/tlpt_datapath.sv =====
module tlpt_datapath
  import tlpt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  input  req_t req,
  input  logic [31:0] pool_base,
  output stat_t stat,
  output rsp_t rsp
);

  logic [31:0] l1_mem [L1Depth];
  logic [31:0] l2_mem [NumCoarseTables * 256];

  req_t r;
  logic [31:0] l1_q, e, se;
  logic [31:0] l2_q;
  logic [TableCountBits-1:0] next_free;
  logic [L2AddrBits-1:0] slot, sslot;
  logic slot_ok, sslot_ok;
  logic [7:0] clr_idx;
  logic [TableBits-1:0] clr_tbl;
  logic [L1AddrBits-1:0] init_idx;
  logic [2:0] status;
  logic [31:0] desc;
  logic alloc;
  rsp_t out_q;

  logic [L1AddrBits-1:0] l1_tgt, l1_src, l1_rd;
  logic [L2AddrBits-1:0] l2_rd;
  logic [4:0] perm;
  logic [31:0] base_al, new_entry, clr_value;
  logic [31:0] desc_map, desc_share;
  logic pool_full;
  logic [2:0] ev_status;
  logic ev_alloc, ev_l2, ev_clear_l1, ev_write_l2;

  function automatic logic [L2AddrBits:0] l2_of(input logic [31:0] ent,
      input logic [31:0] va, input logic [31:0] base,
      input logic [TableCountBits-1:0] nf);
    logic [31:0] off;
    logic ok;
    off = {ent[31:9], 9'd0} - base;
    ok = (ent[1:0] == 2'd1 || ent[1:0] == 2'd3) && off[9:0] == 10'd0
      && off[31:10] < {{(22-TableCountBits){1'b0}}, nf}
      && off[31:10] < 22'(NumCoarseTables);
    l2_of = {ok, off[10 +: TableBits], va[19:12]};
  endfunction

  assign base_al = {pool_base[31:10], 10'd0};
  assign l1_tgt = {r.space[SpaceBits-1:0], r.vaddr[31:20]};
  assign l1_src = {r.source_space[SpaceBits-1:0], r.source_vaddr[31:20]};
  assign l1_rd = (cmd == CMD_RD_SRC_L1) ? l1_src : l1_tgt;
  assign l2_rd = (cmd == CMD_CHK_L2) ? sslot : slot;
  assign perm = perm_lookup(r.perm_code);
  assign pool_full = (next_free >= TableCountBits'(NumCoarseTables));
  assign new_entry = (base_al + {{(22-TableCountBits){1'b0}}, next_free, 10'd0}) | 32'd1;
  assign clr_value = (r.operation == OP_SWAP) ? r.swap_id : 32'd0;
  assign desc_map = r.paddr | {22'd0, perm[2], 3'd0, perm[1:0], 4'b0010};
  assign desc_share = {l2_q[31:12], 12'h012};
  assign {slot_ok, slot} = l2_of(e, r.vaddr, base_al, next_free);
  assign {sslot_ok, sslot} = l2_of(se, r.source_vaddr, base_al, next_free);

  // l1_q holds the source entry while evaluating
  always_comb begin
    ev_status = ST_OK;
    ev_alloc = 1'b0;
    ev_l2 = 1'b0;
    ev_clear_l1 = 1'b0;
    ev_write_l2 = 1'b0;
    if (r.vaddr[11:0] != 12'd0) begin
      ev_status = ST_BAD_VADDR;
    end else begin
      case (r.operation)
        OP_MAP: begin
          if (r.paddr[11:0] != 12'd0) ev_status = ST_BAD_PADDR;
          else if (!perm[4]) ev_status = ST_BAD_PERM;
          else if (e[1:0] == 2'd2) ev_status = ST_MAPPED;
          else if (e[1:0] == 2'd0 && pool_full) ev_status = ST_NO_TABLES;
          else if (e[1:0] == 2'd0) ev_alloc = 1'b1;
          else if (!slot_ok) ev_status = ST_NO_TABLES;
          else ev_l2 = 1'b1;
        end
        OP_SHARE: begin
          if (r.source_vaddr[11:0] != 12'd0) ev_status = ST_BAD_PADDR;
          else if (e[1:0] == 2'd2) ev_status = ST_MAPPED;
          else if (l1_q[1:0] == 2'd0 || l1_q[1:0] == 2'd2) ev_status = ST_NOT_MAPPED;
          else if (e[1:0] == 2'd0 && pool_full) ev_status = ST_NO_TABLES;
          else if (e[1:0] == 2'd0) ev_alloc = 1'b1;
          else if (!slot_ok) ev_status = ST_NO_TABLES;
          else ev_l2 = 1'b1;
        end
        default: begin
          if (e[1:0] == 2'd2) ev_clear_l1 = 1'b1;
          else ev_write_l2 = slot_ok;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    l1_q <= l1_mem[l1_rd];
    l2_q <= l2_mem[l2_rd];
    case (cmd)
      CMD_INIT: l1_mem[init_idx] <= '0;
      CMD_EVAL: begin
        if (ev_alloc) l1_mem[l1_tgt] <= new_entry;
        else if (ev_clear_l1) l1_mem[l1_tgt] <= '0;
        if (ev_write_l2) l2_mem[slot] <= clr_value;
      end
      CMD_CLEAR: l2_mem[{clr_tbl, clr_idx}] <= '0;
      CMD_CHK_L2: begin
        if (l2_q == 32'd0 && r.operation == OP_MAP) l2_mem[slot] <= desc_map;
      end
      CMD_CHK_SRC: begin
        if (l2_q != 32'd0 && perm[4]) l2_mem[slot] <= desc_share;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_idx <= '0;
      next_free <= '0;
    end else begin
      case (cmd)
        CMD_INIT: init_idx <= init_idx + L1AddrBits'(1);
        CMD_LOAD: begin
          r <= req;
          status <= ST_OK;
          desc <= '0;
          alloc <= 1'b0;
        end
        CMD_RD_SRC_L1: e <= l1_q;
        CMD_EVAL: begin
          se <= l1_q;
          status <= ev_status;
          if (ev_write_l2) desc <= clr_value;
          if (ev_alloc) begin
            e <= new_entry;
            alloc <= 1'b1;
            next_free <= next_free + TableCountBits'(1);
            clr_tbl <= next_free[TableBits-1:0];
            clr_idx <= '0;
          end
        end
        CMD_CLEAR: clr_idx <= clr_idx + 8'd1;
        CMD_CHK_L2: begin
          if (l2_q != 32'd0) status <= ST_MAPPED;
          else if (r.operation == OP_MAP) desc <= desc_map;
          else if (!sslot_ok) status <= ST_NOT_MAPPED;
        end
        CMD_CHK_SRC: begin
          if (l2_q == 32'd0) status <= ST_NOT_MAPPED;
          else if (!perm[4]) status <= ST_BAD_PERM;
          else desc <= desc_share;
        end
        CMD_OUT: begin
          out_q.status <= status;
          out_q.descriptor <= desc;
          out_q.table_allocated <= alloc;
        end
        default: ;
      endcase
    end
  end

  assign stat.init_last = (init_idx == '1);
  assign stat.ev_alloc = ev_alloc;
  assign stat.ev_l2 = ev_l2;
  assign stat.src_rd = (r.operation == OP_SHARE) && (l2_q == 32'd0) && sslot_ok;
  assign stat.clear_last = (clr_idx == 8'd255);
  assign rsp = out_q;

endmodule

// ===== hdl/two_level_page_table_updater.sv =====
// channel  dir  payload  handshake
// in       in   req_t    in_valid / in_ready
// out      out  rsp_t    out_valid / out_ready
// cfg      in   32 bits  cfg_valid / cfg_ready
// after reset the first-level tables are cleared one word a cycle, all 16384 words
// unmap, mark swapped and early errors pass RD_TGT, RD_SRC, EVAL, FINISH
// map adds CHK_L2, share CHK_SRC too; allocation adds CLEAR (256 words), RD_L2
// input and configuration are ready only while idle
// a result held by out_ready stalls the next request in its last cycle
module two_level_page_table_updater
  import tlpt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [31:0] cfg_data
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_RD_TGT,
    S_RD_SRC,
    S_EVAL,
    S_CLEAR,
    S_RD_L2,
    S_CHK_L2,
    S_CHK_SRC,
    S_FINISH
  } state_t;

  state_t state;
  logic [31:0] pool_base;
  cmd_t cmd;
  stat_t stat;
  logic out_free;

  assign in_ready = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) pool_base <= '0;
    else if (cfg_valid && cfg_ready) pool_base <= cfg_data;
  end

  always_comb begin
    case (state)
      S_INIT: cmd = CMD_INIT;
      S_IDLE: cmd = in_valid ? CMD_LOAD : CMD_NONE;
      S_RD_TGT: cmd = CMD_RD_L1;
      S_RD_SRC: cmd = CMD_RD_SRC_L1;
      S_EVAL: cmd = CMD_EVAL;
      S_CLEAR: cmd = CMD_CLEAR;
      S_RD_L2: cmd = CMD_RD_L2;
      S_CHK_L2: cmd = CMD_CHK_L2;
      S_CHK_SRC: cmd = CMD_CHK_SRC;
      S_FINISH: cmd = out_free ? CMD_OUT : CMD_NONE;
      default: cmd = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_INIT: if (stat.init_last) state <= S_IDLE;
        S_IDLE: if (in_valid) state <= S_RD_TGT;
        S_RD_TGT: state <= S_RD_SRC;
        S_RD_SRC: state <= S_EVAL;
        S_EVAL: begin
          if (stat.ev_alloc) state <= S_CLEAR;
          else if (stat.ev_l2) state <= S_CHK_L2;
          else state <= S_FINISH;
        end
        S_CLEAR: if (stat.clear_last) state <= S_RD_L2;
        S_RD_L2: state <= S_CHK_L2;
        S_CHK_L2: state <= stat.src_rd ? S_CHK_SRC : S_FINISH;
        S_CHK_SRC: state <= S_FINISH;
        S_FINISH: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      if (state == S_FINISH && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  tlpt_datapath datapath (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .req(in_data),
    .pool_base(pool_base),
    .stat(stat),
    .rsp(out_data)
  );

`ifndef NO_ASSERTIONS
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data));
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status <= ST_NO_TABLES);
  a_error_no_desc: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |-> out_data.descriptor == 32'd0);
`endif

endmodule
